[design/bne_pkg.sv]
// bne_pkg: shared types and constants of the box NMS engine.
// Payload structs, register indexes and the Q30 exp2 table.
// No dependencies.
package bne_pkg;

  localparam int NUM_REGS = 2;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam logic [REG_IDX_W-1:0] REG_MODE = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_THR = REG_IDX_W'(1);
  localparam int CFG_DATA_W = 16;
  localparam logic [15:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] class_score;
    logic        last_box;
  } box_in_t;

  typedef struct packed {
    logic [5:0]  load_slot;
    logic [15:0] final_score;
    logic        was_suppressed;
    logic        overflow_seen;
    logic        last_result;
  } nms_res_t;

  function automatic logic [63:0] isqrt_f(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'd1 << 62;
    x = v;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-k) in Q30, entry 0 is 2^29
  function automatic logic [31:0] pow_tbl_f(input int k);
    logic [63:0] t;
    t = 64'd1 << 29;
    for (int n = 1; n <= k; n++) t = isqrt_f(t << 30);
    return t[31:0];
  endfunction

  localparam logic [31:0] POW_TBL [17] = '{
    pow_tbl_f(0), pow_tbl_f(1), pow_tbl_f(2), pow_tbl_f(3), pow_tbl_f(4),
    pow_tbl_f(5), pow_tbl_f(6), pow_tbl_f(7), pow_tbl_f(8), pow_tbl_f(9),
    pow_tbl_f(10), pow_tbl_f(11), pow_tbl_f(12), pow_tbl_f(13), pow_tbl_f(14),
    pow_tbl_f(15), pow_tbl_f(16)
  };

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

endpackage

[design/box_nms_engine_unit.sv]
// box_nms_engine_unit: single-class NMS engine, greedy IoU or distance IoU.
// Uses bne_pkg for payload structs, register indexes and the exp2 table.
//
// channel  | direction | signals                         | transfer when
// ---------+-----------+---------------------------------+------------------
// box load | in        | start_i, busy_o, in_i           | start_i & !busy_o
// result   | out       | res_strobe_o, res_o             | res_strobe_o
// config   | in        | cfg_we_i, cfg_idx_i, cfg_data_i | cfg_we_i
//
// A box is stored while there is room, else it sets the overflow flag. A last_box
// box also starts a run: rank sort, then a pass over the sorted boxes in which each later
// box of a nonzero one is checked in IoU mode or in DIoU mode (16-step divider,
// 16 squarings, 16 exp2 products, all on one shared 32x32 multiplier), then one
// result per stored box.
// busy_o is high for the whole run. Reset clears the counts and the mode register and
// loads THR_RESET into the threshold; the box stores need no clearing. The result side cannot stall.
module box_nms_engine_unit #(
  parameter int MAX_BOXES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  bne_pkg::box_in_t                 in_i,
  output logic                             res_strobe_o,
  output bne_pkg::nms_res_t                res_o,
  input  logic                             cfg_we_i,
  input  logic [bne_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bne_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  localparam logic [5:0] S_IDLE = 6'd0,  S_RI  = 6'd1,  S_LI  = 6'd2,  S_SCAN = 6'd3,
                         S_AI   = 6'd4,  S_AW  = 6'd5,  S_AL  = 6'd6,  S_BI   = 6'd7,
                         S_BW   = 6'd8,  S_BL  = 6'd9,  S_G0  = 6'd10, S_G1   = 6'd11,
                         S_M1   = 6'd12, S_M2  = 6'd13, S_M3  = 6'd14, S_M4   = 6'd15,
                         S_D1   = 6'd16, S_D2  = 6'd17, S_D3  = 6'd18, S_D4   = 6'd19,
                         S_D5   = 6'd20, S_D6  = 6'd21, S_DIV = 6'd22, S_DZ   = 6'd23,
                         S_LG   = 6'd24, S_LSM = 6'd25, S_LSU = 6'd26, S_E    = 6'd27,
                         S_EW   = 6'd28, S_XM  = 6'd29, S_XU  = 6'd30, S_PEN  = 6'd31,
                         S_F1   = 6'd32, S_F2  = 6'd33, S_F3  = 6'd34, S_EA   = 6'd35,
                         S_EB   = 6'd36, S_EC  = 6'd37;

  logic [5:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic ovf_q, ovf_d;
  logic mode_q;
  logic [15:0] thr_q;

  logic [63:0] box_mem [MAX_BOXES];
  logic [16:0] wk_mem [MAX_BOXES];
  logic [AW-1:0] ord_mem [MAX_BOXES];
  logic [63:0] box_rd_q;
  logic [16:0] wk_rd_q;
  logic [AW-1:0] ord_rd_q;
  logic [AW-1:0] ord_raddr, wk_raddr;
  logic box_we, wk_we, ord_we;
  logic [AW-1:0] box_waddr, wk_waddr, ord_waddr;
  logic [16:0] wk_wdata;

  logic [AW-1:0] rank_q, rank_d, cmpj_q, cmpj_d, slot_q, slot_d;
  logic cmpv_q, cmpv_d;
  logic [15:0] si_q, si_d;
  logic [63:0] box_a_q, box_a_d, box_b_q, box_b_d;
  logic [16:0] wkb_q, wkb_d;
  logic signed [19:0] al_q, ar_q, at_q, ab_q, bl_q, br_q, bt_q, bb_q;
  logic signed [19:0] al_d, ar_d, at_d, ab_d, bl_d, br_d, bt_d, bb_d;
  logic signed [19:0] ow_q, oh_q, ex_q, ey_q, ow_d, oh_d, ex_d, ey_d;
  logic [16:0] dx_q, dy_q, dx_d, dy_d;
  logic signed [16:0] dxs, dys;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;
  logic [33:0] inter_q, inter_d;
  logic [35:0] uni_q, uni_d;
  logic [36:0] c_q, c_d;
  logic [34:0] d_q, d_d;
  logic [37:0] rem_q, rem_d, rem2;
  logic [15:0] qt_q, qt_d;
  logic [16:0] r_q, r_d;
  logic [4:0] p_q, p_d, msb;
  logic [16:0] m_q, m_d;
  logic [17:0] mm;
  logic [15:0] frac_q, frac_d, f_q, f_d;
  logic [3:0] step_q, step_d;
  logic [4:0] eq_q, eq_d, tbl_idx;
  logic [30:0] acc_q, acc_d, acc_sh;
  logic [16:0] pen_q, pen_d, tp;
  logic [48:0] low_q, low_d;
  logic [20:0] nl;
  logic [53:0] lhs, rhs;
  logic sup;
  logic [CW-1:0] ip1, jp1;
  logic accept;
  logic res_strobe_q, res_strobe_d;
  bne_pkg::nms_res_t res_q, res_d;
  logic [AW+5:0] slot_ext;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && (state_q == S_IDLE);
  assign res_strobe_o = res_strobe_q;
  assign res_o = res_q;
  assign ip1 = i_q + CW'(1);
  assign jp1 = j_q + CW'(1);
  assign tp = {1'b0, thr_q} + pen_q;
  assign tbl_idx = {1'b0, step_q} + 5'd1;
  assign nl = {5'd16 - p_q, 16'h0} - {5'b0, frac_q};
  assign mm = prod_q[33:16];
  assign rem2 = {rem_q[36:0], 1'b0};
  assign acc_sh = acc_q >> eq_q;
  assign lhs = {4'b0, inter_q, 16'h0};
  assign rhs = {5'b0, low_q} + {1'b0, prod_q[20:0], 32'h0};
  assign sup = lhs > rhs;
  assign slot_ext = {6'b0, slot_q};
  assign dxs = $signed({1'b0, box_a_q[15:0]}) - $signed({1'b0, box_b_q[15:0]});
  assign dys = $signed({1'b0, box_a_q[31:16]}) - $signed({1'b0, box_b_q[31:16]});

  always_comb begin
    msb = '0;
    for (int b = 0; b < 17; b++) begin
      if (r_q[b]) msb = 5'(b);
    end
  end

  always_comb begin
    al_d = $signed({3'b0, box_a_q[15:0], 1'b0}) - $signed({4'b0, box_a_q[47:32]});
    ar_d = $signed({3'b0, box_a_q[15:0], 1'b0}) + $signed({4'b0, box_a_q[47:32]});
    at_d = $signed({3'b0, box_a_q[31:16], 1'b0}) - $signed({4'b0, box_a_q[63:48]});
    ab_d = $signed({3'b0, box_a_q[31:16], 1'b0}) + $signed({4'b0, box_a_q[63:48]});
    bl_d = $signed({3'b0, box_b_q[15:0], 1'b0}) - $signed({4'b0, box_b_q[47:32]});
    br_d = $signed({3'b0, box_b_q[15:0], 1'b0}) + $signed({4'b0, box_b_q[47:32]});
    bt_d = $signed({3'b0, box_b_q[31:16], 1'b0}) - $signed({4'b0, box_b_q[63:48]});
    bb_d = $signed({3'b0, box_b_q[31:16], 1'b0}) + $signed({4'b0, box_b_q[63:48]});
    ow_d = ((ar_q < br_q) ? ar_q : br_q) - ((al_q > bl_q) ? al_q : bl_q);
    oh_d = ((ab_q < bb_q) ? ab_q : bb_q) - ((at_q > bt_q) ? at_q : bt_q);
    ex_d = ((ar_q > br_q) ? ar_q : br_q) - ((al_q < bl_q) ? al_q : bl_q);
    ey_d = ((ab_q > bb_q) ? ab_q : bb_q) - ((at_q < bt_q) ? at_q : bt_q);
    dx_d = {(dxs < 0) ? 16'(-dxs) : dxs[15:0], 1'b0};
    dy_d = {(dys < 0) ? 16'(-dys) : dys[15:0], 1'b0};
  end

  always_comb begin
    ord_raddr = (state_q == S_BI) ? j_q[AW-1:0] : i_q[AW-1:0];
    if (state_q == S_AW || state_q == S_BW || state_q == S_EB) begin
      wk_raddr = ord_rd_q;
    end else if (state_q == S_SCAN) begin
      wk_raddr = j_q[AW-1:0];
    end else begin
      wk_raddr = i_q[AW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;  ovf_d = ovf_q;  i_d = i_q;  j_d = j_q;
    rank_d = rank_q;  cmpj_d = cmpj_q;  cmpv_d = 1'b0;  slot_d = slot_q;
    si_d = si_q;  box_a_d = box_a_q;  box_b_d = box_b_q;  wkb_d = wkb_q;
    inter_d = inter_q;  uni_d = uni_q;  c_d = c_q;  d_d = d_q;
    rem_d = rem_q;  qt_d = qt_q;  r_d = r_q;  p_d = p_q;  m_d = m_q;
    frac_d = frac_q;  f_d = f_q;  step_d = step_q;  eq_d = eq_q;
    acc_d = acc_q;  pen_d = pen_q;  low_d = low_q;
    mul_a = '0;  mul_b = '0;
    box_we = 1'b0;  wk_we = 1'b0;  ord_we = 1'b0;
    box_waddr = cnt_q[AW-1:0];  wk_waddr = cnt_q[AW-1:0];  ord_waddr = rank_q;
    wk_wdata = {1'b0, in_i.class_score};
    res_strobe_d = 1'b0;  res_d = res_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cnt_q < CW'(MAX_BOXES)) begin
            box_we = 1'b1;
            wk_we = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_box) begin
            i_d = '0;
            state_d = S_RI;
          end
        end
      end
      S_RI: state_d = S_LI;
      S_LI: begin
        si_d = wk_rd_q[15:0];
        j_d = '0;
        rank_d = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (j_q < cnt_q) begin
          j_d = jp1;
          cmpv_d = 1'b1;
          cmpj_d = j_q[AW-1:0];
        end
        if (cmpv_q && ((wk_rd_q[15:0] > si_q) ||
            (wk_rd_q[15:0] == si_q && cmpj_q < i_q[AW-1:0]))) begin
          rank_d = rank_q + AW'(1);
        end
        if (!(j_q < cnt_q) && !cmpv_q) begin
          ord_we = 1'b1;
          if (ip1 == cnt_q) begin
            i_d = '0;
            state_d = S_AI;
          end else begin
            i_d = ip1;
            state_d = S_RI;
          end
        end
      end
      S_AI: state_d = S_AW;
      S_AW: state_d = S_AL;
      S_AL: begin
        box_a_d = box_rd_q;
        j_d = ip1;
        if (wk_rd_q[15:0] != 16'h0 && ip1 < cnt_q) begin
          state_d = S_BI;
        end else if (ip1 == cnt_q) begin
          i_d = '0;
          state_d = S_EA;
        end else begin
          i_d = ip1;
          state_d = S_AI;
        end
      end
      S_BI: state_d = S_BW;
      S_BW: begin
        slot_d = ord_rd_q;
        state_d = S_BL;
      end
      S_BL: begin
        box_b_d = box_rd_q;
        wkb_d = wk_rd_q;
        state_d = S_G0;
      end
      S_G0: state_d = S_G1;
      S_G1: state_d = S_M1;
      S_M1: begin
        mul_a = {14'b0, ow_q[17:0]};
        mul_b = {14'b0, oh_q[17:0]};
        state_d = S_M2;
      end
      S_M2: begin
        inter_d = (ow_q > 0 && oh_q > 0) ? prod_q[33:0] : '0;
        mul_a = {16'b0, box_a_q[47:32]};
        mul_b = {16'b0, box_a_q[63:48]};
        state_d = S_M3;
      end
      S_M3: begin
        uni_d = {prod_q[33:0], 2'b0};
        mul_a = {16'b0, box_b_q[47:32]};
        mul_b = {16'b0, box_b_q[63:48]};
        state_d = S_M4;
      end
      S_M4: begin
        uni_d = uni_q + {prod_q[33:0], 2'b0} - {2'b0, inter_q};
        pen_d = '0;
        state_d = mode_q ? S_D1 : S_F1;
      end
      S_D1: begin
        mul_a = {14'b0, ex_q[17:0]};
        mul_b = {14'b0, ex_q[17:0]};
        state_d = S_D2;
      end
      S_D2: begin
        c_d = {1'b0, prod_q[35:0]};
        mul_a = {14'b0, ey_q[17:0]};
        mul_b = {14'b0, ey_q[17:0]};
        state_d = S_D3;
      end
      S_D3: begin
        c_d = c_q + {1'b0, prod_q[35:0]};
        mul_a = {15'b0, dx_q};
        mul_b = {15'b0, dx_q};
        state_d = S_D4;
      end
      S_D4: begin
        d_d = {1'b0, prod_q[33:0]};
        mul_a = {15'b0, dy_q};
        mul_b = {15'b0, dy_q};
        state_d = S_D5;
      end
      S_D5: begin
        d_d = d_q + {1'b0, prod_q[33:0]};
        state_d = S_D6;
      end
      S_D6: begin
        if (c_q == '0) begin
          pen_d = '0;
          state_d = S_F1;
        end else if (thr_q == 16'h0) begin
          pen_d = 17'h10000;
          state_d = S_F1;
        end else if (d_q == '0) begin
          pen_d = '0;
          state_d = S_F1;
        end else if ({2'b0, d_q} >= c_q) begin
          r_d = 17'h10000;
          state_d = S_LG;
        end else begin
          rem_d = {3'b0, d_q};
          qt_d = '0;
          step_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rem2 >= {1'b0, c_q}) begin
          rem_d = rem2 - {1'b0, c_q};
          qt_d = {qt_q[14:0], 1'b1};
        end else begin
          rem_d = rem2;
          qt_d = {qt_q[14:0], 1'b0};
        end
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) state_d = S_DZ;
      end
      S_DZ: begin
        r_d = {1'b0, qt_q};
        if (qt_q == 16'h0) begin
          pen_d = '0;
          state_d = S_F1;
        end else begin
          state_d = S_LG;
        end
      end
      S_LG: begin
        p_d = msb;
        m_d = 17'(r_q << (5'd16 - msb));
        frac_d = '0;
        step_d = '0;
        state_d = S_LSM;
      end
      S_LSM: begin
        mul_a = {15'b0, m_q};
        mul_b = {15'b0, m_q};
        state_d = S_LSU;
      end
      S_LSU: begin
        if (mm[17]) begin
          m_d = mm[17:1];
          frac_d = {frac_q[14:0], 1'b1};
        end else begin
          m_d = mm[16:0];
          frac_d = {frac_q[14:0], 1'b0};
        end
        step_d = step_q + 4'd1;
        state_d = (step_q == 4'd15) ? S_E : S_LSM;
      end
      S_E: begin
        mul_a = {11'b0, nl};
        mul_b = {16'b0, thr_q};
        state_d = S_EW;
      end
      S_EW: begin
        eq_d = prod_q[36:32];
        f_d = prod_q[31:16];
        acc_d = 31'h4000_0000;
        step_d = '0;
        state_d = S_XM;
      end
      S_XM: begin
        mul_a = {1'b0, acc_q};
        mul_b = f_q[4'd15 - step_q] ? bne_pkg::POW_TBL[tbl_idx] : bne_pkg::Q30_ONE;
        state_d = S_XU;
      end
      S_XU: begin
        acc_d = prod_q[60:30];
        step_d = step_q + 4'd1;
        state_d = (step_q == 4'd15) ? S_PEN : S_XM;
      end
      S_PEN: begin
        pen_d = (eq_q >= 5'd31) ? '0 : acc_sh[30:14];
        state_d = S_F1;
      end
      S_F1: begin
        mul_a = {15'b0, tp};
        mul_b = uni_q[31:0];
        state_d = S_F2;
      end
      S_F2: begin
        low_d = prod_q[48:0];
        mul_a = {15'b0, tp};
        mul_b = {28'b0, uni_q[35:32]};
        state_d = S_F3;
      end
      S_F3: begin
        if (sup) begin
          wk_we = 1'b1;
          wk_waddr = slot_q;
          wk_wdata = {wkb_q[16] | (wkb_q[15:0] != 16'h0), 16'h0};
        end
        j_d = jp1;
        if (jp1 < cnt_q) begin
          state_d = S_BI;
        end else if (ip1 == cnt_q) begin
          i_d = '0;
          state_d = S_EA;
        end else begin
          i_d = ip1;
          state_d = S_AI;
        end
      end
      S_EA: state_d = S_EB;
      S_EB: begin
        slot_d = ord_rd_q;
        state_d = S_EC;
      end
      S_EC: begin
        res_strobe_d = 1'b1;
        res_d.load_slot = slot_ext[5:0];
        res_d.final_score = wk_rd_q[15:0];
        res_d.was_suppressed = wk_rd_q[16];
        res_d.overflow_seen = ovf_q;
        res_d.last_result = (ip1 == cnt_q);
        if (ip1 == cnt_q) begin
          cnt_d = '0;
          ovf_d = 1'b0;
          i_d = '0;
          state_d = S_IDLE;
        end else begin
          i_d = ip1;
          state_d = S_EA;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (box_we) box_mem[box_waddr] <= {in_i.box_height, in_i.box_width,
                                       in_i.center_y, in_i.center_x};
    if (wk_we) wk_mem[wk_waddr] <= wk_wdata;
    if (ord_we) ord_mem[ord_waddr] <= i_q[AW-1:0];
    box_rd_q <= box_mem[wk_raddr];
    wk_rd_q <= wk_mem[wk_raddr];
    ord_rd_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      cmpv_q <= 1'b0;
      res_strobe_q <= 1'b0;
      mode_q <= 1'b0;
      thr_q <= bne_pkg::THR_RESET;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      i_q <= i_d;
      j_q <= j_d;
      cmpv_q <= cmpv_d;
      res_strobe_q <= res_strobe_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bne_pkg::REG_MODE: mode_q <= cfg_data_i[0];
          bne_pkg::REG_THR:  thr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;  cmpj_q <= cmpj_d;  slot_q <= slot_d;  si_q <= si_d;
    box_a_q <= box_a_d;  box_b_q <= box_b_d;  wkb_q <= wkb_d;
    al_q <= al_d;  ar_q <= ar_d;  at_q <= at_d;  ab_q <= ab_d;
    bl_q <= bl_d;  br_q <= br_d;  bt_q <= bt_d;  bb_q <= bb_d;
    ow_q <= ow_d;  oh_q <= oh_d;  ex_q <= ex_d;  ey_q <= ey_d;
    dx_q <= dx_d;  dy_q <= dy_d;
    prod_q <= mul_a * mul_b;
    inter_q <= inter_d;  uni_q <= uni_d;  c_q <= c_d;  d_q <= d_d;
    rem_q <= rem_d;  qt_q <= qt_d;  r_q <= r_d;  p_q <= p_d;  m_q <= m_d;
    frac_q <= frac_d;  f_q <= f_d;  step_q <= step_d;  eq_q <= eq_d;
    acc_q <= acc_d;  pen_q <= pen_d;  low_q <= low_d;
    res_q <= res_d;
  end

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o) else $error("back-to-back result strobes");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_BOXES)) else $error("box count beyond capacity");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last_result) |-> (!busy_o && cnt_q == '0))
    else $error("run end did not clear the set");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_i.last_box) |=> busy_o)
    else $error("last box did not start a run");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CW'(MAX_BOXES))) else $error("overflow flag without full store");

endmodule
